/* rtl/core/lpci_pkg.sv */
// Shared widths, types and the result saturation function of the line pair classifier.
package lpci_pkg;

  localparam int COEF_W = 16;
  localparam int PROD_W = 2 * COEF_W;
  localparam int MAG_W = PROD_W + 1;
  localparam int FRAC_W = 16;
  localparam int RES_W = 32;
  localparam int DIV_STEPS = RES_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [MAG_W-1:0] sdiff_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [RES_W-1:0] res_t;

  typedef struct packed {
    logic parallel;
    logic coincident;
    logic perp;
    logic slope_def;
    logic x_neg;
    logic y_neg;
    logic s_neg;
  } side_t;

  typedef struct packed {
    side_t side;
    mag_t nx_mag;
    mag_t ny_mag;
    mag_t det_mag;
    mag_t sn_mag;
    mag_t sd_mag;
  } job_t;

  typedef struct packed {
    res_t val;
    logic sat;
  } res_sat_t;

  function automatic res_sat_t finish(input logic ovf, input res_t quo, input logic neg);
    logic [RES_W:0] mag;
    res_sat_t r;
    mag = ovf ? {1'b1, {RES_W{1'b0}}} : {1'b0, quo};
    r.sat = 1'b0;
    r.val = mag[RES_W-1:0];
    if (!neg && (mag > {2'b00, {(RES_W-1){1'b1}}})) begin
      r.sat = 1'b1;
      r.val = {1'b0, {(RES_W-1){1'b1}}};
    end else if (neg && (mag > {2'b01, {(RES_W-1){1'b0}}})) begin
      r.sat = 1'b1;
      r.val = {1'b1, {(RES_W-1){1'b0}}};
    end else if (neg) begin
      r.val = ~mag[RES_W-1:0] + res_t'(1);
    end
    return r;
  endfunction

endpackage

/* rtl/core/lpci_front.sv */
// Front part: takes line pair beats, forms the cross products and classifies the pair.
module lpci_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lpci_pkg::coef_t  line1_a,
  input  lpci_pkg::coef_t  line1_b,
  input  lpci_pkg::coef_t  line1_c,
  input  lpci_pkg::coef_t  line2_a,
  input  lpci_pkg::coef_t  line2_b,
  input  lpci_pkg::coef_t  line2_c,
  output logic             job_valid,
  input  logic             job_full,
  output lpci_pkg::job_t   job
);

  localparam int PROD_MSB = lpci_pkg::PROD_W - 1;
  localparam int MAG_MSB = lpci_pkg::MAG_W - 1;
  localparam int COEF_MSB = lpci_pkg::COEF_W - 1;

  logic en;
  logic v1;
  logic v2;
  lpci_pkg::prod_t a1b2, a2b1, c1b2, c2b1, a1c2, a2c1, b1c2, b2c1, a1a2, b1b2;
  lpci_pkg::coef_t a1, b1;
  lpci_pkg::sdiff_t det_s, nx_s, ny_s, nbc_s, perp_s;
  lpci_pkg::coef_t a1_abs, b1_abs;
  lpci_pkg::job_t job_next;

  assign en = !v2 || !job_full;
  assign in_stall = !en;
  assign job_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1b2 <= line1_a * line2_b;
      a2b1 <= line2_a * line1_b;
      c1b2 <= line1_c * line2_b;
      c2b1 <= line2_c * line1_b;
      a1c2 <= line1_a * line2_c;
      a2c1 <= line2_a * line1_c;
      b1c2 <= line1_b * line2_c;
      b2c1 <= line2_b * line1_c;
      a1a2 <= line1_a * line2_a;
      b1b2 <= line1_b * line2_b;
      a1 <= line1_a;
      b1 <= line1_b;
      job <= job_next;
    end
  end

  always_comb begin
    det_s = {a1b2[PROD_MSB], a1b2} - {a2b1[PROD_MSB], a2b1};
    nx_s = {c1b2[PROD_MSB], c1b2} - {c2b1[PROD_MSB], c2b1};
    ny_s = {a1c2[PROD_MSB], a1c2} - {a2c1[PROD_MSB], a2c1};
    nbc_s = {b1c2[PROD_MSB], b1c2} - {b2c1[PROD_MSB], b2c1};
    perp_s = {a1a2[PROD_MSB], a1a2} + {b1b2[PROD_MSB], b1b2};
    a1_abs = a1[COEF_MSB] ? -a1 : a1;
    b1_abs = b1[COEF_MSB] ? -b1 : b1;
    job_next.det_mag = lpci_pkg::mag_t'(det_s[MAG_MSB] ? -det_s : det_s);
    job_next.nx_mag = lpci_pkg::mag_t'(nx_s[MAG_MSB] ? -nx_s : nx_s);
    job_next.ny_mag = lpci_pkg::mag_t'(ny_s[MAG_MSB] ? -ny_s : ny_s);
    job_next.sn_mag = lpci_pkg::mag_t'($unsigned(a1_abs));
    job_next.sd_mag = lpci_pkg::mag_t'($unsigned(b1_abs));
    job_next.side.parallel = (det_s == '0);
    job_next.side.coincident = (det_s == '0) && (ny_s == '0) && (nbc_s == '0);
    job_next.side.perp = (perp_s == '0);
    job_next.side.slope_def = (b1 != '0);
    job_next.side.x_neg = (nx_s[MAG_MSB] != det_s[MAG_MSB]) && (nx_s != '0);
    job_next.side.y_neg = (ny_s[MAG_MSB] != det_s[MAG_MSB]) && (ny_s != '0);
    job_next.side.s_neg = (a1 != '0) && ((!a1[COEF_MSB]) != b1[COEF_MSB]);
  end

endmodule

/* rtl/core/lpci_queue.sv */
// Short queue that parts the front and back parts.
module lpci_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            full,
  input  lpci_pkg::job_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_pop,
  output lpci_pkg::job_t  rd_data
);

  lpci_pkg::job_t mem [lpci_pkg::QUEUE_DEPTH];
  logic [lpci_pkg::QPTR_W-1:0] wr_ptr;
  logic [lpci_pkg::QPTR_W-1:0] rd_ptr;
  logic [lpci_pkg::QCNT_W-1:0] count;
  logic push;
  logic pop;

  assign full = (count == lpci_pkg::QCNT_W'(lpci_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign push = wr_valid && !full;
  assign pop = rd_pop && rd_valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/lpci_div.sv */
// Pipelined restoring divider giving a Q16.16 quotient magnitude and an overflow flag.
module lpci_div (
  input  logic            clk,
  input  logic            en,
  input  lpci_pkg::mag_t  num,
  input  lpci_pkg::mag_t  den,
  output logic            ovf,
  output lpci_pkg::res_t  quo
);

  localparam int STEPS = lpci_pkg::DIV_STEPS;
  localparam int MAG_W = lpci_pkg::MAG_W;
  localparam int RES_W = lpci_pkg::RES_W;
  localparam int FRAC_W = lpci_pkg::FRAC_W;

  lpci_pkg::mag_t rem [STEPS+1];
  lpci_pkg::mag_t dv [STEPS+1];
  lpci_pkg::res_t low [STEPS+1];
  lpci_pkg::res_t q [STEPS+1];
  logic of [STEPS+1];
  logic [MAG_W+FRAC_W-1:0] dd;

  assign dd = {num, {FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= lpci_pkg::mag_t'(dd[MAG_W+FRAC_W-1:RES_W]);
      low[0] <= dd[RES_W-1:0];
      q[0] <= '0;
      dv[0] <= den;
      of[0] <= ({{FRAC_W{1'b0}}, num} >= {den, {FRAC_W{1'b0}}});
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [MAG_W:0] t;
    logic [MAG_W:0] d;
    logic ge;
    assign t = {rem[i], low[i][RES_W-1]};
    assign d = t - {1'b0, dv[i]};
    assign ge = (t >= {1'b0, dv[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? d[MAG_W-1:0] : t[MAG_W-1:0];
        q[i+1] <= {q[i][RES_W-2:0], ge};
        low[i+1] <= {low[i][RES_W-2:0], 1'b0};
        dv[i+1] <= dv[i];
        of[i+1] <= of[i];
      end
    end
  end

  assign ovf = of[STEPS];
  assign quo = q[STEPS];

endmodule

/* rtl/core/lpci_back.sv */
// Back part: divides out the intersection and slope, saturates and holds the result beat.
module lpci_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_pop,
  input  lpci_pkg::job_t  job,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            is_parallel,
  output logic            is_coincident,
  output logic            is_perpendicular,
  output logic            point_valid,
  output lpci_pkg::res_t  cross_x,
  output lpci_pkg::res_t  cross_y,
  output logic            slope_defined,
  output lpci_pkg::res_t  slope_one,
  output logic            saturated
);

  localparam int STAGES = lpci_pkg::DIV_STEPS + 1;

  logic en;
  logic v [STAGES];
  lpci_pkg::side_t sd [STAGES];
  logic x_ovf, y_ovf, s_ovf;
  lpci_pkg::res_t x_quo, y_quo, s_quo;
  lpci_pkg::res_sat_t fx, fy, fs;
  lpci_pkg::side_t last;
  logic pv;

  assign en = !out_valid || !out_stall;
  assign job_pop = en && job_valid;

  lpci_div u_div_x (.clk(clk), .en(en), .num(job.nx_mag), .den(job.det_mag),
                    .ovf(x_ovf), .quo(x_quo));
  lpci_div u_div_y (.clk(clk), .en(en), .num(job.ny_mag), .den(job.det_mag),
                    .ovf(y_ovf), .quo(y_quo));
  lpci_div u_div_s (.clk(clk), .en(en), .num(job.sn_mag), .den(job.sd_mag),
                    .ovf(s_ovf), .quo(s_quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        v[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      v[0] <= job_valid;
      for (int i = 1; i < STAGES; i++) begin
        v[i] <= v[i-1];
      end
      out_valid <= v[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= job.side;
      for (int i = 1; i < STAGES; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  always_comb begin
    last = sd[STAGES-1];
    pv = !last.parallel;
    fx = lpci_pkg::finish(x_ovf, x_quo, last.x_neg);
    fy = lpci_pkg::finish(y_ovf, y_quo, last.y_neg);
    fs = lpci_pkg::finish(s_ovf, s_quo, last.s_neg);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_parallel <= last.parallel;
      is_coincident <= last.coincident;
      is_perpendicular <= last.perp;
      point_valid <= pv;
      cross_x <= pv ? fx.val : '0;
      cross_y <= pv ? fy.val : '0;
      slope_defined <= last.slope_def;
      slope_one <= last.slope_def ? fs.val : '0;
      saturated <= (pv && (fx.sat || fy.sat)) || (last.slope_def && fs.sat);
    end
  end

endmodule

/* rtl/core/line_pair_classify_intersect.sv */
// Top level of the line pair classifier and intersector.
// One line pair beat can be accepted every cycle while in_stall is low, and one result beat leaves per pair, in
// order. The front registers the cross products and then the classified job, the job passes through the queue,
// and the back runs the bit-per-stage quotient pipeline, which yields the 32 result bits of x, y and slope, before
// the result beat is registered.
module line_pair_classify_intersect (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lpci_pkg::coef_t line1_a,
  input  lpci_pkg::coef_t line1_b,
  input  lpci_pkg::coef_t line1_c,
  input  lpci_pkg::coef_t line2_a,
  input  lpci_pkg::coef_t line2_b,
  input  lpci_pkg::coef_t line2_c,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            is_parallel,
  output logic            is_coincident,
  output logic            is_perpendicular,
  output logic            point_valid,
  output lpci_pkg::res_t  cross_x,
  output lpci_pkg::res_t  cross_y,
  output logic            slope_defined,
  output lpci_pkg::res_t  slope_one,
  output logic            saturated
);

  logic f_valid;
  logic q_full;
  lpci_pkg::job_t f_job;
  logic q_valid;
  logic q_pop;
  lpci_pkg::job_t q_job;

  lpci_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .line1_a(line1_a), .line1_b(line1_b), .line1_c(line1_c),
    .line2_a(line2_a), .line2_b(line2_b), .line2_c(line2_c),
    .job_valid(f_valid), .job_full(q_full), .job(f_job)
  );

  lpci_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .full(q_full), .wr_data(f_job),
    .rd_valid(q_valid), .rd_pop(q_pop), .rd_data(q_job)
  );

  lpci_back u_back (
    .clk(clk), .rst(rst), .job_valid(q_valid), .job_pop(q_pop), .job(q_job),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_parallel(is_parallel), .is_coincident(is_coincident),
    .is_perpendicular(is_perpendicular), .point_valid(point_valid),
    .cross_x(cross_x), .cross_y(cross_y), .slope_defined(slope_defined),
    .slope_one(slope_one), .saturated(saturated)
  );

endmodule
